FILE: design/stq_pkg.sv
package stq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Command codes of the request.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_ADDED = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_IDLE  = 2'd2,
        STATUS_FIRED = 2'd3
    } status_t;

    // One queue entry as it is stored in memory.
    typedef struct packed {
        logic [63:0] expiry;
        logic [7:0]  tag;
    } entry_t;

    // Operands handed to the multiply-add unit.
    typedef struct packed {
        logic        start;
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        logic [63:0] addend;
    } mul_req_t;

    // Result of the multiply-add unit.
    typedef struct packed {
        logic        done;
        logic [63:0] sum;
    } mul_rsp_t;

endpackage

FILE: design/sorted_timeout_queue_unit.sv
// Sorted timeout queue. Each request either adds a timeout (expiry = now + delay_seconds *
// counter_frequency, placed after all entries with an equal or earlier expiry) or is a
// periodic tick (next_compare = now + period_seconds * counter_frequency, and the head is
// popped and reported when its expiry is not later than now). Every request returns exactly
// one result. Requests are handled one at a time, each through the two-stage multiply-add;
// an add to a queue that is neither empty nor full then walks back from the tail, moving
// each entry with a later expiry up one slot, one entry per cycle, through the entry memory
// with its one read and one write port. A stalled result holds off the next request. The
// queue is a ring in that memory, so a pop only moves the head pointer. Registers are
// written through the APB port: counter_frequency at address 0, period_seconds at 4.
module sorted_timeout_queue_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // Request channel.
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [63:0]                  now,
    input  logic [31:0]                  delay_seconds,
    input  logic [7:0]                   tag,
    // Result channel.
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [7:0]                   fired_tag,
    output logic [63:0]                  next_compare,
    output logic [4:0]                   queue_count,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import stq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_PLACE = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [31:0]          freq_reg;
    logic [15:0]          period_reg;
    logic                 cmd_reg;
    logic [63:0]          now_reg;
    logic [7:0]           tag_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    status_t              res_status_reg, res_status_next;
    logic [7:0]           res_tag_reg, res_tag_next;
    logic [63:0]          res_cmp_reg, res_cmp_next;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [7:0]           out_tag_reg;
    logic [63:0]          out_cmp_reg;
    logic [4:0]           out_count_reg;

    entry_t               mem [QUEUE_DEPTH];
    entry_t               rd_data_reg;
    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    entry_t               wr_data;

    mul_req_t             mul_req;
    mul_rsp_t             mul_rsp;

    logic                 in_fire;
    logic                 out_load;
    logic                 cfg_write;
    logic [COUNT_W-1:0]   count_m1;
    logic [COUNT_W+4:0]   count_ext;

    // Physical slot of a logical queue position.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W:0]   off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + off;
        if (s >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            s = s - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign count_m1 = count_reg - COUNT_W'(1);

    // Configuration registers, decoded by word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {16'b0, period_reg} : freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= 32'd62500000;
            period_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                period_reg <= pwdata[15:0];
            end
            else
            begin
                freq_reg <= pwdata;
            end
        end
    end

    // Both products share one multiply-add unit.
    always_comb
    begin
        mul_req.start  = in_fire;
        mul_req.mul_a  = (cmd == CMD_ADD) ? delay_seconds : {16'b0, period_reg};
        mul_req.mul_b  = freq_reg;
        mul_req.addend = now;
    end

    stq_mul_add u_mul_add (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Entry memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer: compute, then walk back from the tail shifting later entries up one slot.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_cmp_next    = res_cmp_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = '{expiry: mul_rsp.sum, tag: tag_reg};
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (mul_rsp.done)
                begin
                    if (cmd_reg == CMD_TICK)
                    begin
                        res_cmp_next = mul_rsp.sum;
                        state_next   = ST_RESP;
                        if ((count_reg != '0) && (rd_data_reg.expiry <= now_reg))
                        begin
                            res_status_next = STATUS_FIRED;
                            res_tag_next    = rd_data_reg.tag;
                            head_next       = slot(head_reg, (IDX_W + 1)'(1));
                            count_next      = count_m1;
                        end
                        else
                        begin
                            res_status_next = STATUS_IDLE;
                            res_tag_next    = 8'd0;
                        end
                    end
                    else
                    begin
                        res_cmp_next = 64'd0;
                        res_tag_next = 8'd0;
                        if (count_reg == COUNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_RESP;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en           = 1'b1;
                            count_next      = count_reg + COUNT_W'(1);
                            res_status_next = STATUS_ADDED;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = slot(head_reg, {1'b0, count_m1[IDX_W-1:0]});
                            idx_next   = count_m1[IDX_W-1:0];
                            state_next = ST_SHIFT;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, {1'b0, idx_reg} + (IDX_W + 1)'(1));
                if (rd_data_reg.expiry > mul_rsp.sum)
                begin
                    // Later entry moves up; keep walking toward the head.
                    wr_data = rd_data_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = slot(head_reg, {1'b0, idx_reg - IDX_W'(1)});
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    count_next      = count_reg + COUNT_W'(1);
                    res_status_next = STATUS_ADDED;
                    state_next      = ST_RESP;
                end
            end
            ST_PLACE:
            begin
                // New entry becomes the head.
                wr_en           = 1'b1;
                count_next      = count_reg + COUNT_W'(1);
                res_status_next = STATUS_ADDED;
                state_next      = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {5'b0, count_reg};

    // Request capture, walk index and result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd;
            now_reg <= now;
            tag_reg <= tag;
        end
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_cmp_reg    <= res_cmp_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_tag_reg    <= res_tag_reg;
            out_cmp_reg    <= res_cmp_reg;
            out_count_reg  <= count_ext[4:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign fired_tag    = out_tag_reg;
    assign next_compare = out_cmp_reg;
    assign queue_count  = out_count_reg;

endmodule

FILE: design/stq_mul_add.sv
module stq_mul_add (
    input  logic              clk,
    input  logic              rst_n,
    input  stq_pkg::mul_req_t req,
    output stq_pkg::mul_rsp_t rsp
);
    import stq_pkg::*;

    logic        stage1_reg;
    logic        stage2_reg;
    logic [63:0] prod_reg;
    logic [63:0] addend_reg;
    logic [63:0] sum_reg;

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
        end
        else
        begin
            stage1_reg <= req.start;
            stage2_reg <= stage1_reg;
        end
    end

    // First stage multiplies, second stage adds; the sum holds until the next request.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg   <= {32'b0, req.mul_a} * {32'b0, req.mul_b};
            addend_reg <= req.addend;
        end
        if (stage1_reg)
        begin
            sum_reg <= prod_reg + addend_reg;
        end
    end

    assign rsp.done = stage2_reg;
    assign rsp.sum  = sum_reg;

endmodule

FILE: test/sorted_timeout_queue_checker.sv
module sorted_timeout_queue_checker #(
    parameter logic [2:0] FREQ_ADDR   = 3'd0,
    parameter logic [2:0] PERIOD_ADDR = 3'd4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [63:0] now,
    input  logic [31:0] delay_seconds,
    input  logic [7:0]  tag,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [7:0]  fired_tag,
    input  logic [63:0] next_compare,
    input  logic [4:0]  queue_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          awaited
);
    timeunit 1ns;
    timeprecision 1ps;
    import stq_pkg::*;

    // What one request is expected to return.
    typedef struct packed {
        status_t     status;
        logic [7:0]  fired_tag;
        logic [63:0] next_compare;
        logic [4:0]  queue_count;
    } timer_result_t;

    // Shadow copy of the registers and of the pending timeouts, kept in expiry order.
    logic [31:0]   frequency;
    logic [15:0]   period;
    entry_t        pending_timers[$];
    timer_result_t due_results[$];
    int            mismatches;

    // Apply one request to the shadow queue and return the result it must produce.
    function automatic timer_result_t timer_step(input logic op, input logic [63:0] at,
                                                 input logic [31:0] secs,
                                                 input logic [7:0] handle);
        timer_result_t res;
        entry_t        slot;
        int            pos;
        res.fired_tag    = '0;
        res.next_compare = '0;
        if (op == CMD_ADD)
        begin
            if (pending_timers.size() >= QUEUE_DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                slot.expiry = at + {32'd0, secs} * {32'd0, frequency};
                slot.tag    = handle;
                // Equal expiries keep arrival order, so walk past them.
                pos = 0;
                while (pos < pending_timers.size() && pending_timers[pos].expiry <= slot.expiry)
                    pos++;
                pending_timers.insert(pos, slot);
                res.status = STATUS_ADDED;
            end
        end
        else
        begin
            res.next_compare = at + {48'd0, period} * {32'd0, frequency};
            if (pending_timers.size() > 0 && pending_timers[0].expiry <= at)
            begin
                slot          = pending_timers.pop_front();
                res.fired_tag = slot.tag;
                res.status    = STATUS_FIRED;
            end
            else
            begin
                res.status = STATUS_IDLE;
            end
        end
        res.queue_count = 5'(pending_timers.size());
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Track register writes, predict each accepted request and compare each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            frequency = 32'd62500000;
            period    = 16'd1;
            pending_timers.delete();
            due_results.delete();
            mismatches = 0;
            fail_count <= 0;
            awaited    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == FREQ_ADDR)
                    frequency = pwdata;
                else if (paddr == PERIOD_ADDR)
                    period = pwdata[15:0];
            end
            if (in_valid && !in_stall)
                due_results.push_back(timer_step(cmd, now, delay_seconds, tag));
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result expected none, got status %0d tag %0h", $time,
                             status, fired_tag);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("fired_tag", 64'(want.fired_tag), 64'(fired_tag));
                    check_field("next_compare", want.next_compare, next_compare);
                    check_field("queue_count", 64'(want.queue_count), 64'(queue_count));
                end
            end
            fail_count <= mismatches;
            awaited    <= due_results.size();
        end
    end

endmodule

FILE: test/sorted_timeout_queue_unit_tb.sv
module sorted_timeout_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stq_pkg::*;

    localparam logic [2:0] ADDR_FREQUENCY = 3'd0;
    localparam logic [2:0] ADDR_PERIOD    = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [63:0] now;
    logic [31:0] delay_seconds;
    logic [7:0]  tag;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  fired_tag;
    logic [63:0] next_compare;
    logic [4:0]  queue_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          awaited;
    logic        steady;
    logic [63:0] clock_now;

    sorted_timeout_queue_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .now          (now),
        .delay_seconds(delay_seconds),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .fired_tag    (fired_tag),
        .next_compare (next_compare),
        .queue_count  (queue_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sorted_timeout_queue_checker #(
        .FREQ_ADDR  (ADDR_FREQUENCY),
        .PERIOD_ADDR(ADDR_PERIOD)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .now          (now),
        .delay_seconds(delay_seconds),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .fired_tag    (fired_tag),
        .next_compare (next_compare),
        .queue_count  (queue_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .awaited      (awaited)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side stalls at random, except during the steady stretch.
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 26);

    // Present one request, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_request(input logic op, input logic [63:0] at,
                                input logic [31:0] secs, input logic [7:0] handle);
        if (!steady)
        begin
            while ($urandom_range(99) < 26)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        now           <= at;
        delay_seconds <= secs;
        tag           <= handle;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain_results;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    // One register write: setup cycle, then access until pready. psel is left high so
    // that writes can follow back to back.
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic apply_settings(input logic [31:0] freq, input logic [15:0] secs);
        cfg_write(ADDR_FREQUENCY, freq);
        cfg_write(ADDR_PERIOD, {16'd0, secs});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A run of random requests under one register setting. Most requests follow a clock
    // that only moves forward; bursts lean toward adds or toward ticks so that the queue
    // both fills up and drains. A few requests carry fully random fields.
    task automatic run_random(input int count, input logic [31:0] freq,
                              input logic [15:0] secs);
        int fill_pct;
        drain_results();
        apply_settings(freq, secs);
        fill_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
                fill_pct = $urandom_range(1) ? 80 : 25;
            if ($urandom_range(99) < 10)
            begin
                send_request(1'($urandom_range(1)), {$urandom, $urandom}, $urandom,
                             8'($urandom));
            end
            else
            begin
                clock_now += 64'(freq) * $urandom_range(1) + $urandom_range(2);
                if ($urandom_range(99) < fill_pct)
                    send_request(CMD_ADD, clock_now, $urandom_range(6), 8'($urandom));
                else
                    send_request(CMD_TICK, clock_now, $urandom, 8'($urandom));
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_ADD;
        now           = '0;
        delay_seconds = '0;
        tag           = '0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady        = 1'b0;
        clock_now     = 64'd200_000_000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset register values.
        // Ticks on an empty queue, one of them with a compare value that wraps.
        send_request(CMD_TICK, 64'd0, 32'd0, 8'h00);
        send_request(CMD_TICK, '1, '1, '1);
        // An expiry of zero, an expiry that wraps, and a tie that must go behind the first.
        send_request(CMD_ADD, 64'd0, 32'd0, 8'h00);
        send_request(CMD_ADD, '1, '1, 8'hFF);
        send_request(CMD_ADD, 64'd0, 32'd0, 8'h01);
        // Both zero-expiry entries fire in arrival order, then the head is not yet due.
        send_request(CMD_TICK, 64'd0, 32'd0, 8'h00);
        send_request(CMD_TICK, 64'd0, 32'd0, 8'h00);
        send_request(CMD_TICK, 64'd5, 32'd0, 8'h00);
        // Fill the queue with entries landing at varied places, then overflow it.
        for (int i = 0; i < 15; i++)
            send_request(CMD_ADD, 64'(i) * 7, 32'((15 - i) % 4), 8'(16 + i));
        send_request(CMD_ADD, 64'd0, 32'd0, 8'h55);

        run_random(250, 32'd1, 16'd0);
        run_random(250, 32'hFFFF_FFFF, 16'hFFFF);
        steady = 1'b1;
        run_random(300, 32'd5, 16'd3);
        steady = 1'b0;
        run_random(150, 32'd0, 16'd7);
        run_random(250, 32'd1000, 16'd2);

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("sorted_timeout_queue_unit_tb: clean");
        else
            $display("sorted_timeout_queue_unit_tb: errors");
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin
        #5_000_000;
        $display("sorted_timeout_queue_unit_tb: errors");
        $finish;
    end

endmodule
